[rtl/core/mct_pkg.sv]
package mct_pkg;

    localparam int BYTE_W         = 8;
    localparam int CFG_W          = 13;
    localparam int COORD_BITS_DEF = 13;
    localparam int CURSOR_SIZE    = 6;

    localparam logic [CFG_W-1:0] SCREEN_W_RST = 13'd1024;
    localparam logic [CFG_W-1:0] SCREEN_H_RST = 13'd768;
    localparam int POS_X_RST = 512;
    localparam int POS_Y_RST = 384;

    // header bits carrying the delta signs
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;

    typedef enum logic [0:0] {
        REG_SCREEN_W = 1'b0,
        REG_SCREEN_H = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        BYTE_HDR = 2'd0,
        BYTE_X   = 2'd1,
        BYTE_Y   = 2'd2
    } byte_pos_t;

    // complete packet leaving the assembler this cycle
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] x_byte;
        logic [BYTE_W-1:0] y_byte;
    } pkt_t;

endpackage

[rtl/core/mct_packet_asm.sv]
module mct_packet_asm (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  logic [mct_pkg::BYTE_W-1:0] in_data,
    input  logic                       in_mouse,
    output logic                       in_ready,
    input  logic                       hold,
    output mct_pkg::pkt_t              pkt
);

    logic                       valid_reg, valid_next;
    logic [mct_pkg::BYTE_W-1:0] byte_reg;
    logic                       mouse_reg;
    mct_pkg::byte_pos_t         idx_reg, idx_next;
    logic [mct_pkg::BYTE_W-1:0] hdr_reg, hdr_next;
    logic [mct_pkg::BYTE_W-1:0] xb_reg, xb_next;
    logic                       is_last;
    logic                       advance;
    logic                       take;

    always_comb begin
        is_last  = mouse_reg && (idx_reg == mct_pkg::BYTE_Y);
        // a completing byte waits while the result register is still occupied
        advance  = valid_reg && !(is_last && hold);
        in_ready = !valid_reg || advance;
        take     = in_valid && in_ready;

        pkt.valid  = advance && is_last;
        pkt.header = hdr_reg;
        pkt.x_byte = xb_reg;
        pkt.y_byte = byte_reg;

        idx_next = idx_reg;
        hdr_next = hdr_reg;
        xb_next  = xb_reg;
        if (advance && mouse_reg) begin
            case (idx_reg)
                mct_pkg::BYTE_HDR: begin
                    hdr_next = byte_reg;
                    idx_next = mct_pkg::BYTE_X;
                end
                mct_pkg::BYTE_X: begin
                    xb_next  = byte_reg;
                    idx_next = mct_pkg::BYTE_Y;
                end
                default: begin
                    idx_next = mct_pkg::BYTE_HDR;
                end
            endcase
        end

        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= mct_pkg::BYTE_HDR;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
        hdr_reg <= hdr_next;
        xb_reg  <= xb_next;
        if (take) begin
            byte_reg  <= in_data;
            mouse_reg <= in_mouse;
        end
    end

endmodule

[rtl/core/mct_cursor_update.sv]
module mct_cursor_update #(
    parameter int COORD_BITS = mct_pkg::COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mct_pkg::pkt_t             pkt,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [mct_pkg::CFG_W-1:0] cfg_data,
    input  logic                      m_ready,
    output logic                      m_valid,
    output logic [COORD_BITS-1:0]     cursor_x,
    output logic [COORD_BITS-1:0]     cursor_y,
    output logic                      hold
);

    localparam int SW = ((COORD_BITS > mct_pkg::CFG_W) ? COORD_BITS : mct_pkg::CFG_W) + 2;
    localparam int MASK_BITS = (COORD_BITS < mct_pkg::CFG_W) ? COORD_BITS : mct_pkg::CFG_W;
    localparam logic [mct_pkg::CFG_W-1:0] SIZE_MASK =
        mct_pkg::CFG_W'((33'd1 << MASK_BITS) - 33'd1);

    logic [mct_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [COORD_BITS-1:0]     pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0]     pos_y_reg, pos_y_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [8:0]         dx9, dy9;
    logic signed [SW-1:0]      vx, vy;

    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [SW-1:0]      v,
        input logic [mct_pkg::CFG_W-1:0] size
    );
        logic signed [SW-1:0] lim;
        logic signed [SW-1:0] r;
        lim = $signed(SW'(size & SIZE_MASK)) - $signed(SW'(mct_pkg::CURSOR_SIZE));
        if (lim < 0) begin
            lim = '0;
        end
        r = v;
        if (r < 0) begin
            r = '0;
        end
        if (r >= lim) begin
            r = lim;
        end
        return r[COORD_BITS-1:0];
    endfunction

    always_comb begin
        // 9-bit two's complement: sign from the header, low bits from the data byte
        dx9 = $signed({pkt.header[mct_pkg::X_SIGN_BIT], pkt.x_byte});
        dy9 = $signed({pkt.header[mct_pkg::Y_SIGN_BIT], pkt.y_byte});
        vx  = $signed(SW'(pos_x_reg)) + SW'(dx9);
        vy  = $signed(SW'(pos_y_reg)) - SW'(dy9);

        hold = m_valid_reg && !m_ready;

        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        m_valid_next = m_valid_reg;
        if (pkt.valid) begin
            pos_x_next   = clamp_coord(vx, width_reg);
            pos_y_next   = clamp_coord(vy, height_reg);
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= mct_pkg::SCREEN_W_RST;
            height_reg  <= mct_pkg::SCREEN_H_RST;
            pos_x_reg   <= COORD_BITS'(mct_pkg::POS_X_RST);
            pos_y_reg   <= COORD_BITS'(mct_pkg::POS_Y_RST);
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && (cfg_index == mct_pkg::REG_SCREEN_W)) begin
                width_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == mct_pkg::REG_SCREEN_H)) begin
                height_reg <= cfg_data;
            end
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // position register doubles as the result register
    assign m_valid  = m_valid_reg;
    assign cursor_x = pos_x_reg;
    assign cursor_y = pos_y_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pkt.valid && hold))
        else $error("packet completed while result still pending");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        pkt.valid |=> m_valid_reg)
        else $error("completed packet produced no result");

    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pkt.valid |=> $stable(pos_x_reg) && $stable(pos_y_reg))
        else $error("cursor moved without a packet");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result pending after reset");

endmodule

[rtl/core/ps2_mouse_cursor_tracker.sv]
// Cursor tracker for a PS/2 mouse: accepts one controller byte per cycle
// (s_from_mouse low drops the byte), groups mouse bytes into 3-byte
// packets, and after each third byte outputs the cursor moved by the 9-bit
// X delta and opposite to the Y delta, clamped to 0..screen size - 6.
// One request per clock is sustained unless input stalls; the last byte of
// a packet passes the byte register, then the position/result register.
// Input stalls only when a packet completes while the previous result has
// not been taken. Screen size is set through cfg (index 0 width, 1 height);
// the user writes it only while the block is idle (not enforced).
module ps2_mouse_cursor_tracker #(
    parameter int COORD_BITS = mct_pkg::COORD_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [mct_pkg::BYTE_W-1:0] s_data_byte,
    input  logic                       s_from_mouse,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [COORD_BITS-1:0]      m_cursor_x,
    output logic [COORD_BITS-1:0]      m_cursor_y,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [mct_pkg::CFG_W-1:0]  cfg_data
);

    mct_pkg::pkt_t pkt;
    logic          hold;

    mct_packet_asm u_asm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_data  (s_data_byte),
        .in_mouse (s_from_mouse),
        .in_ready (s_ready),
        .hold     (hold),
        .pkt      (pkt)
    );

    mct_cursor_update #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pkt       (pkt),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .cursor_x  (m_cursor_x),
        .cursor_y  (m_cursor_y),
        .hold      (hold)
    );

endmodule
